>>> hdl/cmbs_pkg.sv
// ----------------------------------------------------------------------------
// Cube map sampler package
// Shared types and constants for the cube map bilinear sampler.
// ----------------------------------------------------------------------------
package cmbs_pkg;

    localparam int COORD_W = 17;
    localparam logic [COORD_W-1:0] ONE_Q16 = 17'd65536;
    localparam logic [COORD_W-1:0] HALF_Q16 = 17'd32768;
    localparam logic [2:0] NUM_FACES = 3'd6;
    localparam logic [2:0] FACE_NEG_Z = 3'd5;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [15:0] SKY_RED = 16'd128;
    localparam logic [15:0] SKY_GREEN = 16'd179;
    localparam logic [15:0] SKY_BLUE = 16'd256;

    localparam logic REG_FACE_SIZE = 1'b0;
    localparam logic REG_MAP_VALID = 1'b1;

    // Divider request/response between sequencer and divider.
    typedef struct packed {
        logic        start;
        logic [17:0] num;
        logic [15:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [17:0] quot;
    } div_rsp_t;

endpackage

>>> hdl/cube_map_bilinear_sampler.sv
// ----------------------------------------------------------------------------
// Cube map bilinear sampler
// Stores six faces of RGB texels and returns bilinearly filtered samples.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           carries
//  input     in         in_valid/in_stall   write texel or sample direction
//  output    out        out_valid/out_stall face, u, v and filtered color
//  config    in         APB psel/penable    face_size, map_valid
//
// A texel write is accepted whenever the block is idle, and writes can follow
// back to back. A filtered sample runs two serial 33-step divisions in the
// shared restoring divider, then four texel reads from the texel store, a
// blend step and a final step per channel, and the output handshake; the next
// transaction is accepted only after that. A sample along the zero direction
// skips the divisions; a sky-color sample goes straight to the output.
// Reset clears control state only; the texel store holds unknown data until
// written. The result sits in an output register; a stalled result blocks
// the next transaction.
module cube_map_bilinear_sampler
#(
    parameter int FACE_MAX = 64,
    parameter int CHANNEL_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [15:0] dir_x,
    input  logic [15:0] dir_y,
    input  logic [15:0] dir_z,
    input  logic [2:0]  tex_face,
    input  logic [5:0]  tex_col,
    input  logic [5:0]  tex_row,
    input  logic [15:0] tex_red,
    input  logic [15:0] tex_green,
    input  logic [15:0] tex_blue,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  face,
    output logic [16:0] u_coord,
    output logic [16:0] v_coord,
    output logic [15:0] red,
    output logic [15:0] green,
    output logic [15:0] blue,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cmbs_pkg::*;

    localparam int XW = $clog2(FACE_MAX);
    localparam int AW = $clog2(6 * FACE_MAX * FACE_MAX);
    localparam int DEPTH = 6 * FACE_MAX * FACE_MAX;
    localparam int CB = CHANNEL_BITS;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_DIVU  = 9'b000000010,
        ST_DIVV  = 9'b000000100,
        ST_SCALE = 9'b000001000,
        ST_READ  = 9'b000010000,
        ST_BLEND = 9'b000100000,
        ST_FINAL = 9'b001000000,
        ST_OUT   = 9'b010000000,
        ST_WAIT  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [6:0] face_size_reg;
    logic       map_valid_reg;
    logic       cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            face_size_reg <= 7'd64;
            map_valid_reg <= 1'b0;
        end
        else if (cfg_wr && paddr[2] == REG_FACE_SIZE && paddr[1:0] == 2'd0)
            face_size_reg <= pwdata[6:0];
        else if (cfg_wr && paddr[2] == REG_MAP_VALID && paddr[1:0] == 2'd0)
            map_valid_reg <= pwdata[0];
    end
    always_comb
    begin
        case (paddr[2])
            REG_FACE_SIZE: prdata = {25'd0, face_size_reg};
            REG_MAP_VALID: prdata = {31'd0, map_valid_reg};
            default:       prdata = '0;
        endcase
    end

    // Effective size minus one, kept at ten bits.
    logic [9:0] smax;
    always_comb
    begin
        if (face_size_reg == 7'd0)
            smax = '0;
        else if (10'(face_size_reg) > 10'(FACE_MAX))
            smax = 10'(FACE_MAX - 1);
        else
            smax = 10'(face_size_reg) - 10'd1;
    end

    // Texel store.
    logic [3*CB-1:0] mem [DEPTH];
    logic [3*CB-1:0] rd_data_reg;
    logic [AW-1:0]   rd_addr;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;

    logic accept;
    assign in_stall = (state_reg != ST_IDLE);
    assign accept = in_valid && !in_stall;
    assign wr_en = accept && cmd == CMD_WRITE && tex_face < NUM_FACES
                   && 32'(tex_col) < FACE_MAX && 32'(tex_row) < FACE_MAX;
    assign wr_addr = AW'((32'(tex_face) * FACE_MAX + 32'(tex_row)) * FACE_MAX
                         + 32'(tex_col));

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= {tex_blue[CB-1:0], tex_green[CB-1:0], tex_red[CB-1:0]};
        rd_data_reg <= mem[rd_addr];
    end

    // Face selection on the incoming direction.
    logic signed [16:0] sx, sy, sz, mu, mv, maj_s;
    logic [16:0] ax, ay, az;
    logic [2:0]  fsel;
    always_comb
    begin
        sx = 17'(signed'(dir_x));
        sy = 17'(signed'(dir_y));
        sz = 17'(signed'(dir_z));
        ax = sx[16] ? 17'(-sx) : 17'(sx);
        ay = sy[16] ? 17'(-sy) : 17'(sy);
        az = sz[16] ? 17'(-sz) : 17'(sz);
        if (ax >= ay && ax >= az)
        begin
            maj_s = signed'(ax);
            fsel = (!sx[16] && sx != 0) ? 3'd0 : 3'd1;
            mu = (fsel == 3'd0) ? -sz : sz;
            mv = -sy;
        end
        else if (ay >= az)
        begin
            maj_s = signed'(ay);
            fsel = (!sy[16] && sy != 0) ? 3'd2 : 3'd3;
            mu = sx;
            mv = (fsel == 3'd2) ? sz : -sz;
        end
        else
        begin
            maj_s = signed'(az);
            fsel = (!sz[16] && sz != 0) ? 3'd4 : 3'd5;
            mu = (fsel == 3'd4) ? sx : -sx;
            mv = -sy;
        end
    end

    logic [2:0]  face_reg;
    logic [15:0] maj_reg;
    logic [17:0] nv_reg;
    logic [16:0] u_reg, v_reg;
    logic [XW+16:0] px_reg, py_reg;
    logic [1:0]  tap_reg;
    logic [CB-1:0] tx_reg [4][3];
    logic [15:0] red_reg, green_reg, blue_reg;
    logic        out_valid_reg;

    div_req_t dreq;
    div_rsp_t drsp;
    cmbs_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic signed [17:0] nu_s, nv_s;
    assign nu_s = 18'(mu) + 18'(maj_s);
    assign nv_s = 18'(mv) + 18'(maj_s);

    always_comb
    begin
        dreq.start = 1'b0;
        dreq.num = 18'(nu_s);
        dreq.den = maj_reg;
        if (state_reg == ST_IDLE && accept && cmd == CMD_SAMPLE && map_valid_reg
            && maj_s != 0)
        begin
            dreq.start = 1'b1;
            dreq.den = maj_s[15:0];
        end
        else if (state_reg == ST_DIVU && drsp.done)
        begin
            dreq.start = 1'b1;
            dreq.num = nv_reg;
        end
    end

    // Tap addresses.
    logic [XW-1:0] x0, y0, x1, y1, cx, cy;
    logic [15:0]   fx, fy;
    always_comb
    begin
        x0 = px_reg[XW+15:16];
        y0 = py_reg[XW+15:16];
        fx = px_reg[15:0];
        fy = py_reg[15:0];
        x1 = (10'(x0) < smax) ? x0 + XW'(1) : x0;
        y1 = (10'(y0) < smax) ? y0 + XW'(1) : y0;
        cx = tap_reg[0] ? x1 : x0;
        cy = tap_reg[1] ? y1 : y0;
        rd_addr = AW'((32'(face_reg) * FACE_MAX + 32'(cy)) * FACE_MAX + 32'(cx));
    end

    // Blend works on one channel at a time.
    function automatic logic [CB-1:0] mix(input logic [CB-1:0] a,
                                          input logic [CB-1:0] b,
                                          input logic [15:0] f);
        logic [CB+16:0] s;
        s = (CB+17)'(a) * (CB+17)'(ONE_Q16 - 17'(f)) + (CB+17)'(b) * (CB+17)'(f);
        return s[CB+15:16];
    endfunction

    logic [1:0] ch_reg;
    logic [CB-1:0] r0, r1, bl;
    always_comb
    begin
        r0 = mix(tx_reg[0][ch_reg], tx_reg[1][ch_reg], fx);
        r1 = mix(tx_reg[2][ch_reg], tx_reg[3][ch_reg], fx);
        bl = r0;
        if (state_reg == ST_FINAL)
            bl = mix(tx_reg[0][ch_reg], tx_reg[1][ch_reg], fy);
    end

    logic rd_pend_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept && cmd == CMD_SAMPLE)
                    state_next = !map_valid_reg ? ST_OUT
                               : (maj_s == 0) ? ST_SCALE : ST_DIVU;
            ST_DIVU:  if (drsp.done) state_next = ST_DIVV;
            ST_DIVV:  if (drsp.done) state_next = ST_SCALE;
            ST_SCALE: state_next = ST_READ;
            ST_READ:  if (rd_pend_reg && tap_reg == 2'd3) state_next = ST_BLEND;
            ST_BLEND: state_next = ST_FINAL;
            ST_FINAL: if (ch_reg == 2'd2) state_next = ST_OUT;
                      else state_next = ST_BLEND;
            ST_OUT:   state_next = ST_WAIT;
            ST_WAIT:  if (!out_stall) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // A read is issued for tap t while rd_pend_reg is low and captured in the next
    // cycle; the tap counter holds until that capture and then steps on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            tap_reg       <= '0;
            ch_reg        <= '0;
            rd_pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT)
                out_valid_reg <= 1'b1;
            else if (state_reg == ST_WAIT && !out_stall)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_SCALE)
            begin
                tap_reg <= '0;
                rd_pend_reg <= 1'b0;
                ch_reg <= '0;
            end
            else if (state_reg == ST_READ)
            begin
                rd_pend_reg <= !rd_pend_reg;
                if (rd_pend_reg)
                    tap_reg <= tap_reg + 2'd1;
            end
            else if (state_reg == ST_FINAL)
                ch_reg <= ch_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && accept)
        begin
            maj_reg <= maj_s[15:0];
            nv_reg  <= 18'(nv_s);
            if (!map_valid_reg)
            begin
                face_reg  <= '0;
                u_reg     <= '0;
                v_reg     <= '0;
                red_reg   <= SKY_RED;
                green_reg <= SKY_GREEN;
                blue_reg  <= SKY_BLUE;
            end
            else if (maj_s == 0)
            begin
                face_reg <= FACE_NEG_Z;
                u_reg    <= HALF_Q16;
                v_reg    <= HALF_Q16;
            end
            else
                face_reg <= fsel;
        end
        if (state_reg == ST_DIVU && drsp.done)
            u_reg <= drsp.quot[16:0];
        if (state_reg == ST_DIVV && drsp.done)
            v_reg <= drsp.quot[16:0];
        if (state_reg == ST_SCALE)
        begin
            px_reg <= (XW+17)'(u_reg * smax[XW-1:0]);
            py_reg <= (XW+17)'(v_reg * smax[XW-1:0]);
        end
        if (state_reg == ST_READ && rd_pend_reg)
            for (int c = 0; c < 3; c++)
                tx_reg[tap_reg][c] <= rd_data_reg[c*CB +: CB];
        if (state_reg == ST_BLEND)
        begin
            tx_reg[0][ch_reg] <= r0;
            tx_reg[1][ch_reg] <= r1;
        end
        if (state_reg == ST_FINAL)
        begin
            case (ch_reg)
                2'd0:    red_reg   <= 16'(bl);
                2'd1:    green_reg <= 16'(bl);
                default: blue_reg  <= 16'(bl);
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign face    = face_reg;
    assign u_coord = u_reg;
    assign v_coord = v_reg;
    assign red     = red_reg;
    assign green   = green_reg;
    assign blue    = blue_reg;

    // The block never accepts while a result is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("accept with result pending");
    // A divider start only happens while a sample is being taken or in U.
    assert property (@(posedge clk) disable iff (!rst_n)
        dreq.start |-> (state_reg == ST_IDLE || state_reg == ST_DIVU))
        else $error("divider started out of sequence");
    // Selected face stays in range.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> face < NUM_FACES) else $error("face out of range");

endmodule

>>> hdl/cmbs_divider.sv
// ----------------------------------------------------------------------------
// Cube map sampler divider
// Restoring divider, one quotient bit per cycle, shared by both coordinates.
// ----------------------------------------------------------------------------
module cmbs_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmbs_pkg::div_req_t req,
    output cmbs_pkg::div_rsp_t rsp
);
    import cmbs_pkg::*;

    // Numerator is (minor+major) <= 2*major, scaled by 2^15; quotient <= 2^16.
    localparam int QW = 33;

    logic [QW-1:0] num_reg, num_next;
    logic [16:0]   rem_reg, rem_next;
    logic [15:0]   den_reg, den_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [17:0]   trial;

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, num_reg[QW-1]} - {2'b00, den_reg};
        if (req.start)
        begin
            num_next  = {req.num, 15'd0};
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = 6'(QW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[17])
            begin
                rem_next = trial[16:0];
                num_next = {num_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[15:0], num_reg[QW-1]};
                num_next = {num_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = (num_reg[QW-1:17] != '0) ? 18'(ONE_Q16) : num_reg[17:0];

endmodule

>>> tb/cmbs_checker.sv
// ----------------------------------------------------------------------------
// Cube map sampler checker
// Watches the texel, sample, result and register channels of the sampler,
// predicts every filtered sample and compares it field by field.
// ----------------------------------------------------------------------------
module cmbs_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        cmd,
    input  logic [15:0] dir_x,
    input  logic [15:0] dir_y,
    input  logic [15:0] dir_z,
    input  logic [2:0]  tex_face,
    input  logic [5:0]  tex_col,
    input  logic [5:0]  tex_row,
    input  logic [15:0] tex_red,
    input  logic [15:0] tex_green,
    input  logic [15:0] tex_blue,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  face,
    input  logic [16:0] u_coord,
    input  logic [16:0] v_coord,
    input  logic [15:0] red,
    input  logic [15:0] green,
    input  logic [15:0] blue,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          errors,
    output int          pending
);
    import cmbs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int EDGE = 64;
    localparam int DEPTH = 6 * EDGE * EDGE;
    localparam logic [2:0] FACE_POS_X = 3'd0;
    localparam logic [2:0] FACE_NEG_X = 3'd1;
    localparam logic [2:0] FACE_POS_Y = 3'd2;
    localparam logic [2:0] FACE_NEG_Y = 3'd3;
    localparam logic [2:0] FACE_POS_Z = 3'd4;

    typedef struct packed {
        logic [2:0]  face;
        logic [16:0] u;
        logic [16:0] v;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } sample_t;

    logic [15:0] red_mem   [DEPTH];
    logic [15:0] green_mem [DEPTH];
    logic [15:0] blue_mem  [DEPTH];
    logic [6:0]  size_reg;
    logic        valid_reg;
    sample_t     sample_q[$];

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // Projects one minor component onto the face, UQ1.16 with clamping at 1.0.
    function automatic logic [16:0] face_coord(input longint minor, input longint major);
        longint q;
        q = ((minor + major) * 32768) / major;
        if (q > 65536)
            q = 65536;
        return q[16:0];
    endfunction

    function automatic longint lerp(input longint a, input longint b, input longint f);
        return (a * (65536 - f) + b * f) >>> 16;
    endfunction

    function automatic longint fetch(input int f, input int col, input int row, input int ch);
        int idx;
        idx = (f * EDGE + row) * EDGE + col;
        case (ch)
            0: return red_mem[idx];
            1: return green_mem[idx];
            default: return blue_mem[idx];
        endcase
    endfunction

    function automatic sample_t filtered_sample(input logic [15:0] dx, input logic [15:0] dy,
                                                input logic [15:0] dz);
        sample_t r;
        longint x, y, z, ax, ay, az, major, uc, vc, px, py, fx, fy, r0, r1, mixed;
        int s, x0, x1, y0, y1;
        r = '0;
        if (!valid_reg) begin
            r.red = SKY_RED;
            r.green = SKY_GREEN;
            r.blue = SKY_BLUE;
            return r;
        end
        x = longint'($signed(dx));
        y = longint'($signed(dy));
        z = longint'($signed(dz));
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        az = z < 0 ? -z : z;
        if (ax == 0 && ay == 0 && az == 0) begin
            r.face = FACE_NEG_Z;
            r.u = HALF_Q16;
            r.v = HALF_Q16;
        end else begin
            // Ties favor X, then Y; a zero major component picks the negative face.
            if (ax >= ay && ax >= az) begin
                major = ax;
                if (x > 0) begin r.face = FACE_POS_X; uc = -z; vc = -y; end
                else       begin r.face = FACE_NEG_X; uc = z;  vc = -y; end
            end else if (ay >= az) begin
                major = ay;
                if (y > 0) begin r.face = FACE_POS_Y; uc = x; vc = z;  end
                else       begin r.face = FACE_NEG_Y; uc = x; vc = -z; end
            end else begin
                major = az;
                if (z > 0) begin r.face = FACE_POS_Z; uc = x;  vc = -y; end
                else       begin r.face = FACE_NEG_Z; uc = -x; vc = -y; end
            end
            r.u = face_coord(uc, major);
            r.v = face_coord(vc, major);
        end
        s = size_reg == 0 ? 1 : (size_reg > EDGE ? EDGE : int'(size_reg));
        px = longint'(r.u) * (s - 1);
        py = longint'(r.v) * (s - 1);
        x0 = int'(px >>> 16);
        y0 = int'(py >>> 16);
        fx = px & 16'hFFFF;
        fy = py & 16'hFFFF;
        if (x0 > s - 1) x0 = s - 1;
        if (y0 > s - 1) y0 = s - 1;
        x1 = x0 + 1 < s ? x0 + 1 : s - 1;
        y1 = y0 + 1 < s ? y0 + 1 : s - 1;
        for (int ch = 0; ch < 3; ch++) begin
            r0 = lerp(fetch(r.face, x0, y0, ch), fetch(r.face, x1, y0, ch), fx);
            r1 = lerp(fetch(r.face, x0, y1, ch), fetch(r.face, x1, y1, ch), fx);
            mixed = lerp(r0, r1, fy) & 16'hFFFF;
            case (ch)
                0: r.red = mixed[15:0];
                1: r.green = mixed[15:0];
                default: r.blue = mixed[15:0];
            endcase
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        sample_t want;
        int idx;
        if (!rst_n) begin
            size_reg <= 7'd64;
            valid_reg <= 1'b0;
            errors = 0;
            pending = 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (sample_q.size() == 0) begin
                    report("unexpected result", 1, 0);
                end else begin
                    want = sample_q.pop_front();
                    if (face !== want.face) report("face", face, want.face);
                    if (u_coord !== want.u) report("u_coord", u_coord, want.u);
                    if (v_coord !== want.v) report("v_coord", v_coord, want.v);
                    if (red !== want.red) report("red", red, want.red);
                    if (green !== want.green) report("green", green, want.green);
                    if (blue !== want.blue) report("blue", blue, want.blue);
                end
            end
            if (in_valid && !in_stall) begin
                if (cmd == CMD_SAMPLE) begin
                    sample_q.push_back(filtered_sample(dir_x, dir_y, dir_z));
                end else if (tex_face < NUM_FACES) begin
                    idx = (int'(tex_face) * EDGE + int'(tex_row)) * EDGE + int'(tex_col);
                    red_mem[idx] = tex_red;
                    green_mem[idx] = tex_green;
                    blue_mem[idx] = tex_blue;
                end
            end
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
                if (paddr[2] == REG_FACE_SIZE)
                    size_reg <= pwdata[6:0];
                else
                    valid_reg <= pwdata[0];
            end
            pending = sample_q.size();
        end
    end

endmodule

>>> tb/cube_map_bilinear_sampler_test.sv
// ----------------------------------------------------------------------------
// Cube map sampler testbench
// Drives texel writes, sample requests and register writes with random gaps
// and stalls; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module cube_map_bilinear_sampler_test;
    import cmbs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Edge of the filled corner of every face; face sizes in the random phases stay within it.
    localparam int FILL = 8;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        cmd;
    logic [15:0] dir_x;
    logic [15:0] dir_y;
    logic [15:0] dir_z;
    logic [2:0]  tex_face;
    logic [5:0]  tex_col;
    logic [5:0]  tex_row;
    logic [15:0] tex_red;
    logic [15:0] tex_green;
    logic [15:0] tex_blue;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  face;
    logic [16:0] u_coord;
    logic [16:0] v_coord;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int errors;
    int pending;

    // When these are clear, the matching side runs back to back.
    bit gaps_on;
    bit stalls_on;

    cube_map_bilinear_sampler dut (.*);

    cmbs_checker u_checker (.*);

    // The clock runs with a 12 ns period.
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 0;
    end

    // The result side draws a stall length for every transaction it takes,
    // then holds the stall low until a result has been accepted.
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            n = stalls_on ? $urandom_range(0, 5) : 0;
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
        end
    end

    // Sends one transaction after a random gap, and returns once it is accepted.
    task automatic send(input logic c, input logic [15:0] x, input logic [15:0] y,
                        input logic [15:0] z, input logic [2:0] f, input logic [5:0] col,
                        input logic [5:0] row, input logic [47:0] rgb);
        int n;
        n = gaps_on ? $urandom_range(0, 5) : 0;
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        dir_x <= x;
        dir_y <= y;
        dir_z <= z;
        tex_face <= f;
        tex_col <= col;
        tex_row <= row;
        {tex_red, tex_green, tex_blue} <= rgb;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic sample(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
        send(CMD_SAMPLE, x, y, z, 3'($urandom), 6'($urandom), 6'($urandom),
             48'({$urandom, $urandom}));
    endtask

    task automatic store_texel(input logic [2:0] f, input logic [5:0] col, input logic [5:0] row);
        send(CMD_WRITE, 16'($urandom), 16'($urandom), 16'($urandom), f, col, row,
             48'({$urandom, $urandom}));
    endtask

    // Lets every outstanding sample drain, then gives a trailing texel write
    // time to settle, so the block is idle before a register changes.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic reg_write(input logic idx, input logic [31:0] value);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Direction components mix full-range values, tiny values, the extremes
    // and copies of another component, so that ties and zeros come up often.
    function automatic logic [15:0] component(input logic [15:0] other);
        case ($urandom_range(0, 7))
            0, 1, 2: return 16'($urandom);
            3: return 16'($signed($urandom_range(0, 8)) - 4);
            4: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            5: return other;
            6: return -other;
            default: return 16'd0;
        endcase
    endfunction

    task automatic random_item();
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            x = component(16'($urandom));
            y = component(x);
            z = component($urandom_range(0, 1) ? x : y);
            sample(x, y, z);
        end
        else if (pick < 95)
            store_texel(3'($urandom_range(0, 5)), 6'($urandom_range(0, FILL - 1)),
                        6'($urandom_range(0, FILL - 1)));
        else
            store_texel(3'($urandom_range(6, 7)), 6'($urandom), 6'($urandom));
    endtask

    // A hard ceiling on the run, far beyond the slowest correct run.
    initial
    begin
        #25ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int sizes[8];
        sizes = '{8, 1, 0, 2, 5, 8, 3, 7};
        in_valid = 1'b0;
        cmd = CMD_WRITE;
        dir_x = '0;
        dir_y = '0;
        dir_z = '0;
        tex_face = '0;
        tex_col = '0;
        tex_row = '0;
        tex_red = '0;
        tex_green = '0;
        tex_blue = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Out of reset the map is not valid, so every sample answers with the
        // sky color; writes to the two nonexistent faces are dropped.
        sample(16'h7FFF, 16'h0001, 16'h8000);
        sample(16'h0000, 16'h0000, 16'h0000);
        store_texel(3'd6, 6'd63, 6'd0);
        store_texel(3'd7, 6'd0, 6'd63);
        sample(16'h8000, 16'h8000, 16'h8000);

        // Fill the corner of every face that the face sizes in use can reach,
        // plus the four center texels of the -Z face that the zero direction
        // reads at full size, before any filtered read can happen.
        gaps_on = 1'b0;
        for (int f = 0; f < 6; f++)
            for (int row = 0; row < FILL; row++)
                for (int col = 0; col < FILL; col++)
                    store_texel(3'(f), 6'(col), 6'(row));
        send(CMD_WRITE, '0, '0, '0, 3'd0, 6'd0, 6'd0, 48'h0);
        send(CMD_WRITE, '0, '0, '0, 3'd5, 6'(FILL - 1), 6'(FILL - 1), 48'hFFFF_FFFF_FFFF);
        store_texel(FACE_NEG_Z, 6'd31, 6'd31);
        store_texel(FACE_NEG_Z, 6'd32, 6'd31);
        store_texel(FACE_NEG_Z, 6'd31, 6'd32);
        store_texel(FACE_NEG_Z, 6'd32, 6'd32);
        gaps_on = 1'b1;

        reg_write(REG_MAP_VALID, 32'd1);
        reg_write(REG_FACE_SIZE, 32'(FILL));
        // Directed directions: the zero vector, each face, ties between axes,
        // zero major components and the most negative value on every axis.
        sample(16'h0000, 16'h0000, 16'h0000);
        sample(16'h7FFF, 16'h0000, 16'h0000);
        sample(16'h8000, 16'h0000, 16'h0000);
        sample(16'h0000, 16'h7FFF, 16'h0000);
        sample(16'h0000, 16'h8000, 16'h0000);
        sample(16'h0000, 16'h0000, 16'h7FFF);
        sample(16'h0000, 16'h0000, 16'h8000);
        sample(16'd100, 16'd100, 16'd100);
        sample(-16'd100, 16'd100, -16'd100);
        sample(16'd5, 16'd9, 16'd9);
        sample(16'd5, -16'd9, 16'd9);
        sample(16'h8000, 16'h8000, 16'h8000);
        sample(16'h7FFF, 16'h8000, 16'h7FFF);
        sample(16'd1, 16'hFFFF, 16'd1);
        sample(16'h8000, 16'h7FFF, 16'h8001);
        sample(16'd3, 16'd1, -16'd2);

        // A face size above the largest face acts as the largest face; the
        // zero direction then reads only the filled center of the -Z face.
        reg_write(REG_FACE_SIZE, 32'd127);
        sample(16'h0000, 16'h0000, 16'h0000);
        reg_write(REG_FACE_SIZE, 32'd0);
        sample(16'h7FFF, 16'h1234, 16'h8000);

        // Random phases, each with its own face size; one phase turns the
        // map off again, and gaps and stalls switch off in some phases.
        for (int p = 0; p < 8; p++)
        begin
            reg_write(REG_FACE_SIZE, p == 7 ? $urandom_range(1, FILL) : sizes[p]);
            reg_write(REG_MAP_VALID, p == 4 ? 32'd0 : 32'd1);
            gaps_on = (p % 3) != 1;
            stalls_on = (p % 4) != 2;
            repeat (130) random_item();
        end
        gaps_on = 1'b1;
        stalls_on = 1'b1;

        drain();
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
